### rtl/core/assert_macros.svh
// Assertion macros for the RTL files of this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/evr_pkg.sv
// Types, constants, sine ROM and fixed-point helpers for the Euler rotator.
package evr_pkg;

	localparam int QUARTER_ENTRIES = 256;
	localparam int QBITS           = $clog2(QUARTER_ENTRIES);

	localparam int IN_W    = 16;
	localparam int ANGLE_W = 10;
	localparam int OUT_W   = 18;
	localparam int FRAC_W  = 14;

	localparam int ANG_EXT_W = (ANGLE_W > QBITS + 2) ? ANGLE_W : QBITS + 2;
	localparam int MAG_W     = FRAC_W + 1;
	localparam int TRIG_W    = MAG_W + 1;
	localparam int COORD_W   = OUT_W;
	localparam int PROD_W    = COORD_W + TRIG_W;
	localparam int SUM_W     = PROD_W + 1;

	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

	typedef logic        [MAG_W-1:0]   mag_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic        [ANG_EXT_W-1:0] ang_t;
	typedef mag_t rom_t [QUARTER_ENTRIES];

	localparam trig_t TRIG_ONE = trig_t'(1 << FRAC_W);

	// floor(a*b / 2^60), both below 2^62
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[123:60];
	endfunction

	// floor(n / d) by shift and subtract, d nonzero
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem    = rem - {1'b0, d};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Quarter-wave table, Taylor series in Q60; evaluated at elaboration only.
	function automatic rom_t build_sine_rom();
		rom_t        rom;
		logic [63:0] step;
		logic [63:0] rem;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic        subtract;
		step = HALF_PI_Q60 / QUARTER_ENTRIES;
		rem  = HALF_PI_Q60 % QUARTER_ENTRIES;
		for (int i = 0; i < QUARTER_ENTRIES; i++) begin
			x        = step * 64'(i) + (rem * 64'(i)) / QUARTER_ENTRIES;
			x2       = mul_q60(x, x);
			term     = x;
			sum      = x;
			subtract = 1'b1;
			for (int k = 1; k < 40; k++) begin
				if (term != 64'd0) begin
					term     = div_u64(mul_q60(term, x2), 64'(2 * k) * 64'(2 * k + 1));
					sum      = subtract ? sum - term : sum + term;
					subtract = !subtract;
				end
			end
			rom[i] = MAG_W'(sum >> 46);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_sine_rom();

	// sine in Q1.14 by quadrant folding of the quarter-wave table
	function automatic trig_t sin_q14(input ang_t ang);
		logic [1:0]       quad;
		logic [QBITS-1:0] r;
		logic [QBITS-1:0] r_mirror;
		mag_t             mag;
		trig_t            val;
		quad     = ang[QBITS+1:QBITS];
		r        = ang[QBITS-1:0];
		r_mirror = QBITS'(0) - r;
		if (!quad[0])
			mag = SINE_ROM[r];
		else if (r == '0)
			mag = MAG_W'(1 << FRAC_W);
		else
			mag = SINE_ROM[r_mirror];
		val = trig_t'(mag);
		return quad[1] ? -val : val;
	endfunction

	function automatic trig_t cos_q14(input ang_t ang);
		return sin_q14(ang + ang_t'(QUARTER_ENTRIES));
	endfunction

	function automatic prod_t mul_ct(input coord_t a, input trig_t b);
		return prod_t'(a) * prod_t'(b);
	endfunction

	// (p + q) >>> 14, floor
	function automatic coord_t q14_add(input prod_t p, input prod_t q);
		sum_t s;
		s = sum_t'(p) + sum_t'(q);
		return coord_t'(s >>> FRAC_W);
	endfunction

	// (p - q) >>> 14, floor
	function automatic coord_t q14_sub(input prod_t p, input prod_t q);
		sum_t s;
		s = sum_t'(p) - sum_t'(q);
		return coord_t'(s >>> FRAC_W);
	endfunction

endpackage

### rtl/core/euler_vector_rotation.sv
// Euler rotator: 7 register stages; 1/cycle while in_stall is low.
// Stages: sine/cosine lookup, then product and sum stages for heading, roll and pitch.
// Each stage after the lookup holds one level of 18x16 multiplies or of 35-bit adds with shift; that sets the clock.
// Stalls ripple back only through full stages, so bubbles close up under out_stall.
// Reset (arst_n low) clears the stage valid bits; data registers are not reset.
`include "assert_macros.svh"

module euler_vector_rotation
	import evr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [IN_W-1:0]    in_x,
	input  logic signed [IN_W-1:0]    in_y,
	input  logic signed [IN_W-1:0]    in_z,
	input  logic        [ANGLE_W-1:0] roll_angle,
	input  logic        [ANGLE_W-1:0] pitch_angle,
	input  logic        [ANGLE_W-1:0] heading_angle,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [OUT_W-1:0]   out_x,
	output logic signed [OUT_W-1:0]   out_y,
	output logic signed [OUT_W-1:0]   out_z
);

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	// stage advance: a stage loads when empty or when it drains downstream
	logic adv_1, adv_2, adv_3, adv_4, adv_5, adv_6, adv_7;

	// stage 1: point and trig values
	coord_t x_s1, y_s1, z_s1;
	trig_t  ch_s1, sh_s1, cr_s1, sr_s1, cp_s1, sp_s1;
	// stage 2: heading products
	prod_t  hcx_s2, hsz_s2, hsx_s2, hcz_s2;
	coord_t y_s2;
	trig_t  cr_s2, sr_s2, cp_s2, sp_s2;
	// stage 3: after heading
	coord_t x_s3, y_s3, z_s3;
	trig_t  cr_s3, sr_s3, cp_s3, sp_s3;
	// stage 4: roll products
	prod_t  rcx_s4, rsy_s4, rsx_s4, rcy_s4;
	coord_t z_s4;
	trig_t  cp_s4, sp_s4;
	// stage 5: after roll
	coord_t x_s5, y_s5, z_s5;
	trig_t  cp_s5, sp_s5;
	// stage 6: pitch products
	prod_t  pcy_s6, psz_s6, psy_s6, pcz_s6;
	coord_t x_s6;
	// stage 7: result
	coord_t x_s7, y_s7, z_s7;

	assign adv_7 = !v_s7 || !out_stall;
	assign adv_6 = !v_s6 || adv_7;
	assign adv_5 = !v_s5 || adv_6;
	assign adv_4 = !v_s4 || adv_5;
	assign adv_3 = !v_s3 || adv_4;
	assign adv_2 = !v_s2 || adv_3;
	assign adv_1 = !v_s1 || adv_2;

	assign in_stall = !adv_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv_1) v_s1 <= in_valid;
			if (adv_2) v_s2 <= v_s1;
			if (adv_3) v_s3 <= v_s2;
			if (adv_4) v_s4 <= v_s3;
			if (adv_5) v_s5 <= v_s4;
			if (adv_6) v_s6 <= v_s5;
			if (adv_7) v_s7 <= v_s6;
		end
	end

	// stage 1: ROM lookups, six reads of the constant table
	always_ff @(posedge clk) begin
		if (adv_1 && in_valid) begin
			x_s1  <= coord_t'(in_x);
			y_s1  <= coord_t'(in_y);
			z_s1  <= coord_t'(in_z);
			ch_s1 <= cos_q14(ang_t'(heading_angle));
			sh_s1 <= sin_q14(ang_t'(heading_angle));
			cr_s1 <= cos_q14(ang_t'(roll_angle));
			sr_s1 <= sin_q14(ang_t'(roll_angle));
			cp_s1 <= cos_q14(ang_t'(pitch_angle));
			sp_s1 <= sin_q14(ang_t'(pitch_angle));
		end
	end

	// stage 2: heading products
	always_ff @(posedge clk) begin
		if (adv_2 && v_s1) begin
			hcx_s2 <= mul_ct(x_s1, ch_s1);
			hsz_s2 <= mul_ct(z_s1, sh_s1);
			hsx_s2 <= mul_ct(x_s1, sh_s1);
			hcz_s2 <= mul_ct(z_s1, ch_s1);
			y_s2   <= y_s1;
			cr_s2  <= cr_s1;
			sr_s2  <= sr_s1;
			cp_s2  <= cp_s1;
			sp_s2  <= sp_s1;
		end
	end

	// stage 3: x = c*x - s*z, z = s*x + c*z
	always_ff @(posedge clk) begin
		if (adv_3 && v_s2) begin
			x_s3  <= q14_sub(hcx_s2, hsz_s2);
			z_s3  <= q14_add(hsx_s2, hcz_s2);
			y_s3  <= y_s2;
			cr_s3 <= cr_s2;
			sr_s3 <= sr_s2;
			cp_s3 <= cp_s2;
			sp_s3 <= sp_s2;
		end
	end

	// stage 4: roll products
	always_ff @(posedge clk) begin
		if (adv_4 && v_s3) begin
			rcx_s4 <= mul_ct(x_s3, cr_s3);
			rsy_s4 <= mul_ct(y_s3, sr_s3);
			rsx_s4 <= mul_ct(x_s3, sr_s3);
			rcy_s4 <= mul_ct(y_s3, cr_s3);
			z_s4   <= z_s3;
			cp_s4  <= cp_s3;
			sp_s4  <= sp_s3;
		end
	end

	// stage 5: x = c*x + s*y, y = c*y - s*x
	always_ff @(posedge clk) begin
		if (adv_5 && v_s4) begin
			x_s5  <= q14_add(rcx_s4, rsy_s4);
			y_s5  <= q14_sub(rcy_s4, rsx_s4);
			z_s5  <= z_s4;
			cp_s5 <= cp_s4;
			sp_s5 <= sp_s4;
		end
	end

	// stage 6: pitch products
	always_ff @(posedge clk) begin
		if (adv_6 && v_s5) begin
			pcy_s6 <= mul_ct(y_s5, cp_s5);
			psz_s6 <= mul_ct(z_s5, sp_s5);
			psy_s6 <= mul_ct(y_s5, sp_s5);
			pcz_s6 <= mul_ct(z_s5, cp_s5);
			x_s6   <= x_s5;
		end
	end

	// stage 7: y = c*y + s*z, z = c*z - s*y
	always_ff @(posedge clk) begin
		if (adv_7 && v_s6) begin
			y_s7 <= q14_add(pcy_s6, psz_s6);
			z_s7 <= q14_sub(pcz_s6, psy_s6);
			x_s7 <= x_s6;
		end
	end

	assign out_valid = v_s7;
	assign out_x     = x_s7;
	assign out_y     = y_s7;
	assign out_z     = z_s7;

	// stall reaches the input only when stage 1 holds a request
	`ASSERT_IMP(a_stall_needs_full, clk, arst_n, in_stall, v_s1, "input stalled with stage 1 empty")
	// an accepted request always lands in stage 1
	`ASSERT_NXT(a_accept_lands, clk, arst_n, in_valid && !in_stall, v_s1, "accepted request lost at stage 1")
	// a bubble in stage 2 is filled from stage 1 at once
	`ASSERT_NXT(a_bubble_fill, clk, arst_n, v_s1 && !v_s2, v_s2, "bubble in stage 2 not filled")
	// zero heading gives cosine of exactly one
	`ASSERT_NXT(a_cos_zero, clk, arst_n, in_valid && !in_stall && heading_angle == '0,
		ch_s1 == TRIG_ONE, "cosine of zero heading is not one")

endmodule
